[design/mbrot_pkg.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel package
// Shared types, constants and helper functions for the escape-time pixel block.
// ----------------------------------------------------------------------------
package mbrot_pkg;

    // Image geometry. The centre of the image maps to the view offset.
    localparam int IMAGE_WIDTH  = 800;
    localparam int IMAGE_HEIGHT = 800;

    // Pixel coordinate width and the width of the doubled, centred coordinate.
    localparam int COORD_W = 10;
    localparam int DELTA_W = 13;

    // Fixed-point format: signed Q8.24.
    localparam int Q_FRAC = 24;
    localparam int VAL_W  = 32;
    localparam int PROD_W = 2 * VAL_W;
    localparam int SAT_W  = 48;

    // Escape radius squared, 4.0 in the Q16.48 product format.
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(4) << (2 * Q_FRAC);

    // Register reset values.
    localparam logic signed [VAL_W-1:0] OFFSET_RESET = '0;
    localparam logic [VAL_W-1:0]        SCALE_RESET  = 32'd83886;
    localparam logic [7:0]              ITER_RESET   = 8'd100;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Colour gradient divisors.
    localparam int Grad5Div = 31;
    localparam int Grad6Div = 63;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_OFFSET_REAL    = 2'd0,
        REG_OFFSET_IMAG    = 2'd1,
        REG_PIXEL_SCALE    = 2'd2,
        REG_MAX_ITERATIONS = 2'd3
    } reg_index_t;

    // Live configuration.
    typedef struct packed {
        logic signed [VAL_W-1:0] offset_real;
        logic signed [VAL_W-1:0] offset_imag;
        logic [VAL_W-1:0]        pixel_scale;
        logic [7:0]              max_iterations;
    } cfg_t;

    // Input beat.
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } pixel_t;

    // Result beat.
    typedef struct packed {
        logic [7:0] iteration_count;
        logic       inside_set;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } result_t;

    // Mapped complex point passed from the front to the back.
    typedef struct packed {
        logic signed [VAL_W-1:0] c_re;
        logic signed [VAL_W-1:0] c_im;
    } point_t;

    // Saturate a wide signed value to the Q8.24 range.
    function automatic logic signed [VAL_W-1:0] sat_q824(input logic signed [SAT_W-1:0] v);
        logic signed [VAL_W-1:0] res;
        if (v[SAT_W-1:VAL_W-1] == '0 || v[SAT_W-1:VAL_W-1] == '1) begin
            res = v[VAL_W-1:0];
        end else if (v[SAT_W-1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    // 255*k/31: 8k plus floor(7k/31), found by comparing against multiples of 31.
    function automatic logic [7:0] grad_32(input logic [4:0] k);
        logic [7:0] y;
        logic [2:0] extra;
        y     = {3'b000, k} * 8'd7;
        extra = '0;
        for (int j = 1; j <= 7; j++) begin
            if (y >= 8'(Grad5Div * j)) begin
                extra = extra + 3'd1;
            end
        end
        return {k, 3'b000} + {5'b00000, extra};
    endfunction

    // 255*k/63: 4k plus floor(3k/63).
    function automatic logic [7:0] grad_64(input logic [5:0] k);
        logic [7:0] y;
        logic [1:0] extra;
        y     = {2'b00, k} * 8'd3;
        extra = '0;
        for (int j = 1; j <= 3; j++) begin
            if (y >= 8'(Grad6Div * j)) begin
                extra = extra + 2'd1;
            end
        end
        return {k, 2'b00} + {6'b000000, extra};
    endfunction

    // 255*k/127: 2k plus one at the top step.
    function automatic logic [7:0] grad_128(input logic [6:0] k);
        return {k, 1'b0} + {7'b0000000, (k == 7'h7f)};
    endfunction

endpackage

[design/mbrot_front.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel front
// Accepts pixel beats and maps each coordinate to its complex point c.
// ----------------------------------------------------------------------------
module mbrot_front
    import mbrot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  pixel_t  in_data,
    output logic    push_valid,
    input  logic    push_ready,
    output point_t  push_data
);

    logic   stage_valid_reg;
    logic   stage_valid_next;
    pixel_t stage_data_reg;
    logic   in_take;

    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W+VAL_W:0] px_prod;
    logic signed [DELTA_W+VAL_W:0] py_prod;
    logic signed [SAT_W-1:0] re_sum;
    logic signed [SAT_W-1:0] im_sum;

    // The stage takes a new beat when it is empty or its point moves on.
    assign in_ready = !stage_valid_reg || push_ready;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take) begin
            stage_valid_next = 1'b1;
        end else if (push_ready) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            stage_data_reg <= in_data;
        end
    end

    // Doubled coordinate relative to the image centre, so odd sizes stay exact.
    assign dx = $signed({2'b00, stage_data_reg.pixel_x, 1'b0}) - $signed(DELTA_W'(IMAGE_WIDTH));
    assign dy = $signed({2'b00, stage_data_reg.pixel_y, 1'b0}) - $signed(DELTA_W'(IMAGE_HEIGHT));

    // Scale, halve rounding toward minus infinity, add the offset and saturate.
    assign px_prod = dx * $signed({1'b0, cfg.pixel_scale});
    assign py_prod = dy * $signed({1'b0, cfg.pixel_scale});
    assign re_sum  = SAT_W'(px_prod >>> 1) + SAT_W'(cfg.offset_real);
    assign im_sum  = SAT_W'(py_prod >>> 1) + SAT_W'(cfg.offset_imag);

    assign push_valid     = stage_valid_reg;
    assign push_data.c_re = sat_q824(re_sum);
    assign push_data.c_im = sat_q824(im_sum);

endmodule

[design/mbrot_queue.sv]
// ----------------------------------------------------------------------------
// Mandelbrot point queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module mbrot_queue
    import mbrot_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_valid,
    output logic   wr_ready,
    input  point_t wr_data,
    output logic   rd_valid,
    input  logic   rd_ready,
    output point_t rd_data
);

    point_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointers wrap naturally since the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/mbrot_back.sv]
// ----------------------------------------------------------------------------
// Mandelbrot iteration engine
// Runs z = z*z + c until escape or the limit, then colours the result.
// ----------------------------------------------------------------------------
module mbrot_back
    import mbrot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  point_t  pop_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [VAL_W-1:0]  cre_reg, cre_next;
    logic signed [VAL_W-1:0]  cim_reg, cim_next;
    logic signed [VAL_W-1:0]  zre_reg, zre_next;
    logic signed [VAL_W-1:0]  zim_reg, zim_next;
    logic [7:0]               n_reg, n_next;
    logic signed [PROD_W-1:0] rr_reg, rr_next;
    logic signed [PROD_W-1:0] ii_reg, ii_next;
    logic signed [PROD_W-1:0] ri_reg, ri_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    load_out;

    logic signed [PROD_W-1:0] diff;
    logic [PROD_W-1:0]        mag_sum;
    logic signed [SAT_W-1:0]  nre_sum;
    logic signed [SAT_W-1:0]  nim_sum;
    logic                     escape;
    logic                     in_set;

    // Squared magnitude and the next z from the registered products.
    assign diff    = rr_reg - ii_reg;
    assign mag_sum = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign nre_sum = SAT_W'(diff >>> Q_FRAC) + SAT_W'(cre_reg);
    assign nim_sum = SAT_W'(ri_reg >>> (Q_FRAC - 1)) + SAT_W'(cim_reg);
    assign escape  = (n_reg >= cfg.max_iterations) || (mag_sum > ESCAPE_LIMIT);
    assign in_set  = (n_reg == cfg.max_iterations);

    assign pop_ready = (state_reg == ST_IDLE);

    // Sequencer: a multiply state, then an add state, for each iteration.
    always_comb
    begin
        state_next    = state_reg;
        cre_next      = cre_reg;
        cim_next      = cim_reg;
        zre_next      = zre_reg;
        zim_next      = zim_reg;
        n_next        = n_reg;
        rr_next       = rr_reg;
        ii_next       = ii_reg;
        ri_next       = ri_reg;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid) begin
                    cre_next   = pop_data.c_re;
                    cim_next   = pop_data.c_im;
                    zre_next   = '0;
                    zim_next   = '0;
                    n_next     = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                rr_next    = zre_reg * zre_reg;
                ii_next    = zim_reg * zim_reg;
                ri_next    = zre_reg * zim_reg;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (escape) begin
                    state_next = ST_DONE;
                end else begin
                    zre_next   = sat_q824(nre_sum);
                    zim_next   = sat_q824(nim_sum);
                    n_next     = n_reg + 8'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result colouring: black inside the set, gradients outside.
    always_comb
    begin
        out_data_next.iteration_count = n_reg;
        out_data_next.inside_set      = in_set;
        if (in_set) begin
            out_data_next.red   = '0;
            out_data_next.green = '0;
            out_data_next.blue  = '0;
        end else begin
            out_data_next.red   = grad_32(n_reg[4:0]);
            out_data_next.green = grad_64(n_reg[5:0]);
            out_data_next.blue  = grad_128(n_reg[6:0]);
        end
    end

    // Output register holds a finished beat until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cre_reg <= cre_next;
        cim_reg <= cim_next;
        zre_reg <= zre_next;
        zim_reg <= zim_next;
        n_reg   <= n_next;
        rr_reg  <= rr_next;
        ii_reg  <= ii_next;
        ri_reg  <= ri_next;
        if (load_out) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel
// Maps a pixel to a complex point, iterates z = z*z + c and returns a colour.
// ----------------------------------------------------------------------------
// A pixel beat is registered in the front, where it is mapped to its point, and
// waits in a two-entry queue until the iteration engine is free. For a pixel
// that stops after n iterations, n is at most max_iterations. The engine has
// one complex multiply-add unit: one state forms the three 32 by 32 products,
// the next checks escape and forms the new z. The front keeps accepting pixels
// while the engine works and while a result waits on the output, until its
// stage and the queue are full. Registers are written through cfg_write,
// cfg_index and cfg_data, and should only be changed while no pixel is in flight.
module mandelbrot_escape_time_pixel
    import mbrot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  pixel_t      in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   push_valid;
    logic   push_ready;
    point_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    point_t pop_data;

    // Configuration register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_index_t'(cfg_index))
                REG_OFFSET_REAL:    cfg_next.offset_real    = $signed(cfg_data);
                REG_OFFSET_IMAG:    cfg_next.offset_imag    = $signed(cfg_data);
                REG_PIXEL_SCALE:    cfg_next.pixel_scale    = cfg_data;
                REG_MAX_ITERATIONS: cfg_next.max_iterations = cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.offset_real    <= OFFSET_RESET;
            cfg_reg.offset_imag    <= OFFSET_RESET;
            cfg_reg.pixel_scale    <= SCALE_RESET;
            cfg_reg.max_iterations <= ITER_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: accepts pixels and maps them to points.
    mbrot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue between the front and the engine.
    mbrot_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // Back: iteration engine and output register.
    mbrot_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[design/mbrot_checker.sv]
// ----------------------------------------------------------------------------
// Mandelbrot pixel checker
// Port-level assertions for the escape-time pixel block, bound to the top.
// ----------------------------------------------------------------------------
module mbrot_checker
    import mbrot_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input result_t     out_data
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // Count of accepted pixels whose results are not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat) begin
            pending_next = pending_reg + 4'd1;
        end else if (out_beat && !in_beat) begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // No result appears without a pixel behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result beat without an accepted pixel");

    // Points inside the set are black.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.inside_set |->
            out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
        else $error("inside point is not black");

    // Outside the set, red is zero exactly when the count is a multiple of 32.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.inside_set |->
            (out_data.red == 8'd0) == (out_data.iteration_count[4:0] == 5'd0))
        else $error("red gradient does not follow the count");

endmodule

bind mandelbrot_escape_time_pixel mbrot_checker u_checker (.*);
